// ----- rtl/zdsa_pkg.sv -----
// ============================================================================
// zdsa_pkg - shared types, constants and zone functions
// Holds the zone geometry of the disk, the request and status codes, the map
// entry layout and the memory request structs used by the allocator.
// ============================================================================
package zdsa_pkg;

    localparam int NUM_TRACKS   = 35;
    localparam int SECTOR_BYTES = 256;
    localparam int DIR_TRACK    = 18;

    localparam int REQ_W  = 2;
    localparam int ST_W   = 2;
    localparam int TRK_W  = 6;
    localparam int SEC_W  = 5;
    localparam int CNT_W  = 5;
    localparam int OFF_W  = 18;
    localparam int IDX_W  = $clog2(NUM_TRACKS);
    localparam int MAX_SPT = 21;

    localparam int SEC_SHIFT = $clog2(SECTOR_BYTES);
    localparam int BLK_W     = OFF_W - SEC_SHIFT;

    // Zone geometry: last track of each zone and its sectors per track.
    localparam int ZONE1_LAST = 17;
    localparam int ZONE2_LAST = 24;
    localparam int ZONE3_LAST = 30;
    localparam int ZONE1_SPT  = 21;
    localparam int ZONE2_SPT  = 19;
    localparam int ZONE3_SPT  = 18;
    localparam int ZONE4_SPT  = 17;

    localparam int ZONE2_BASE = ZONE1_LAST * ZONE1_SPT;
    localparam int ZONE3_BASE = ZONE2_BASE + (ZONE2_LAST - ZONE1_LAST) * ZONE2_SPT;
    localparam int ZONE4_BASE = ZONE3_BASE + (ZONE3_LAST - ZONE2_LAST) * ZONE3_SPT;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FORMAT = 2'd1,
        REQ_MARK   = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_USED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [MAX_SPT-1:0] bitmap;
        logic [CNT_W-1:0]   count;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

    // Sectors on a track, tracks numbered from one.
    function automatic logic [CNT_W-1:0] spt(input logic [TRK_W-1:0] trk);
        logic [CNT_W-1:0] n;
        if (trk <= TRK_W'(ZONE1_LAST)) begin
            n = CNT_W'(ZONE1_SPT);
        end else if (trk <= TRK_W'(ZONE2_LAST)) begin
            n = CNT_W'(ZONE2_SPT);
        end else if (trk <= TRK_W'(ZONE3_LAST)) begin
            n = CNT_W'(ZONE3_SPT);
        end else begin
            n = CNT_W'(ZONE4_SPT);
        end
        return n;
    endfunction

    // Number of sectors on all tracks below the given one.
    function automatic logic [BLK_W-1:0] track_base(input logic [TRK_W-1:0] trk);
        logic [BLK_W-1:0] t;
        logic [BLK_W-1:0] base;
        t = BLK_W'(trk) - BLK_W'(1);
        if (trk <= TRK_W'(ZONE1_LAST)) begin
            base = BLK_W'(ZONE1_SPT) * t;
        end else if (trk <= TRK_W'(ZONE2_LAST)) begin
            base = BLK_W'(ZONE2_BASE) + BLK_W'(ZONE2_SPT) * (t - BLK_W'(ZONE1_LAST));
        end else if (trk <= TRK_W'(ZONE3_LAST)) begin
            base = BLK_W'(ZONE3_BASE) + BLK_W'(ZONE3_SPT) * (t - BLK_W'(ZONE2_LAST));
        end else begin
            base = BLK_W'(ZONE4_BASE) + BLK_W'(ZONE4_SPT) * (t - BLK_W'(ZONE3_LAST));
        end
        return base;
    endfunction

    // Map entry of a freshly formatted disk for a zero-based track index.
    function automatic t_entry fresh_entry(input logic [IDX_W-1:0] idx);
        logic [TRK_W-1:0] trk;
        logic [CNT_W-1:0] n;
        t_entry           e;
        trk = TRK_W'(idx) + TRK_W'(1);
        n = spt(trk);
        e.bitmap = (MAX_SPT'(1) << n) - MAX_SPT'(1);
        e.count = n;
        if (trk == TRK_W'(DIR_TRACK)) begin
            e.bitmap = e.bitmap & ~MAX_SPT'(3);
            e.count = n - CNT_W'(2);
        end
        return e;
    endfunction

endpackage

// ----- rtl/zoned_disk_sector_allocator_unit.sv -----
// ============================================================================
// zoned_disk_sector_allocator_unit - sector availability map for a zoned disk
// Keeps a free bitmap and free count per track and serves allocate, format
// and mark requests, one result item per request item.
// ============================================================================
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------
//  request | in        | i_valid / o_stall   | i_req_type, i_track, i_sector
//  result  | out       | o_valid / i_stall   | o_status, o_out_track,
//          |           |                     | o_out_sector, o_byte_offset,
//          |           |                     | o_track_free
//
//  An allocate item goes from acceptance to S_CHECK, which reads k (1 to
//  NUM_TRACKS) track entries from the map memory, one per cycle, until a
//  free sector is found or the map runs out, and then to S_EMIT. A mark
//  item passes through S_CHECK for its one entry; format and rejected items
//  go straight to S_EMIT. The next item is accepted once the result is loaded.
//  Reset and format restore the fresh map at once through per-track valid
//  flags; no clearing pass is needed.
//  A result waits in the output register while the result side stalls, and
//  the next item is accepted meanwhile; only one item is worked on at a time.
//
module zoned_disk_sector_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [zdsa_pkg::REQ_W-1:0]  i_req_type,
    input  logic [zdsa_pkg::TRK_W-1:0]  i_track,
    input  logic [zdsa_pkg::SEC_W-1:0]  i_sector,

    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [zdsa_pkg::ST_W-1:0]   o_status,
    output logic [zdsa_pkg::TRK_W-1:0]  o_out_track,
    output logic [zdsa_pkg::SEC_W-1:0]  o_out_sector,
    output logic [zdsa_pkg::OFF_W-1:0]  o_byte_offset,
    output logic [zdsa_pkg::CNT_W-1:0]  o_track_free
);

    // S_CHECK examines one map entry per cycle; S_EMIT waits for the output
    // register to be free and hands the pending result over.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    localparam logic [zdsa_pkg::IDX_W-1:0] LAST_IDX =
        zdsa_pkg::IDX_W'(zdsa_pkg::NUM_TRACKS - 1);

    t_state                         r_state;
    logic                           r_alloc;
    logic [zdsa_pkg::IDX_W-1:0]     r_idx;
    logic [zdsa_pkg::SEC_W-1:0]     r_sector;

    // Pending result, built when the work on an item finishes.
    logic [zdsa_pkg::ST_W-1:0]      r_p_status;
    logic [zdsa_pkg::TRK_W-1:0]     r_p_track;
    logic [zdsa_pkg::SEC_W-1:0]     r_p_sector;
    logic [zdsa_pkg::OFF_W-1:0]     r_p_offset;
    logic [zdsa_pkg::CNT_W-1:0]     r_p_free;

    // Output register.
    logic                           r_o_valid;
    logic [zdsa_pkg::ST_W-1:0]      r_o_status;
    logic [zdsa_pkg::TRK_W-1:0]     r_o_track;
    logic [zdsa_pkg::SEC_W-1:0]     r_o_sector;
    logic [zdsa_pkg::OFF_W-1:0]     r_o_offset;
    logic [zdsa_pkg::CNT_W-1:0]     r_o_free;

    logic                           w_in_acc;
    logic                           w_emit;
    logic                           w_trk_ok;
    logic                           w_sec_ok;
    zdsa_pkg::t_rd_req              w_rd;
    zdsa_pkg::t_wr_req              w_wr;
    logic                           w_clear;
    zdsa_pkg::t_entry               w_entry;
    zdsa_pkg::t_entry               w_new;
    logic                           w_found;
    logic [zdsa_pkg::SEC_W-1:0]     w_loc_sec;
    logic [zdsa_pkg::SEC_W-1:0]     w_sel_sec;
    logic                           w_bit;
    logic [zdsa_pkg::TRK_W-1:0]     w_trk;
    logic [zdsa_pkg::BLK_W-1:0]     w_blk;
    logic [zdsa_pkg::OFF_W-1:0]     w_offset;

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    // The pending result moves into the output register once that register
    // is empty or its item is taken in the same cycle.
    assign w_emit   = (r_state == S_EMIT) && (!r_o_valid || !i_stall);

    // A mark item names a track from one to NUM_TRACKS and a sector below
    // that track's sector count.
    assign w_trk_ok = (i_track != '0) &&
                      (i_track <= zdsa_pkg::TRK_W'(zdsa_pkg::NUM_TRACKS));
    assign w_sec_ok = (i_sector < zdsa_pkg::spt(i_track));

    zdsa_map_mem u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (w_rd),
        .i_wr      (w_wr),
        .i_clear   (w_clear),
        .o_rd_data (w_entry)
    );

    zdsa_locate u_locate (
        .i_bitmap (w_entry.bitmap),
        .o_found  (w_found),
        .o_sector (w_loc_sec)
    );

    // Modify step on the entry read in the previous cycle.
    assign w_sel_sec = r_alloc ? w_loc_sec : r_sector;
    assign w_bit     = w_entry.bitmap[w_sel_sec];
    assign w_trk     = zdsa_pkg::TRK_W'(r_idx) + zdsa_pkg::TRK_W'(1);
    assign w_blk     = zdsa_pkg::track_base(w_trk) + zdsa_pkg::BLK_W'(w_sel_sec);
    assign w_offset  = zdsa_pkg::OFF_W'({w_blk, {zdsa_pkg::SEC_SHIFT{1'b0}}});

    always_comb begin
        w_new.bitmap = w_entry.bitmap & ~(zdsa_pkg::MAX_SPT'(1) << w_sel_sec);
        w_new.count  = (w_entry.count != '0) ? (w_entry.count - zdsa_pkg::CNT_W'(1))
                                             : w_entry.count;
    end

    // Memory requests. Reads are issued on acceptance and while the
    // allocation scan moves to the next track; the write-back happens in the
    // cycle the entry is examined, so a read never overlaps a write.
    always_comb begin
        w_rd.en   = 1'b0;
        w_rd.addr = '0;
        w_clear   = 1'b0;
        if (w_in_acc) begin
            case (zdsa_pkg::t_req'(i_req_type))
                zdsa_pkg::REQ_ALLOC: begin
                    w_rd.en = 1'b1;
                end
                zdsa_pkg::REQ_MARK: begin
                    w_rd.en   = w_trk_ok && w_sec_ok;
                    w_rd.addr = zdsa_pkg::IDX_W'(i_track - zdsa_pkg::TRK_W'(1));
                end
                zdsa_pkg::REQ_FORMAT: begin
                    w_clear = 1'b1;
                end
                default: begin
                    w_rd.en = 1'b0;
                end
            endcase
        end else if (r_state == S_CHECK && r_alloc && !w_found && r_idx != LAST_IDX) begin
            w_rd.en   = 1'b1;
            w_rd.addr = r_idx + zdsa_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        w_wr.en   = (r_state == S_CHECK) && (r_alloc ? w_found : w_bit);
        w_wr.addr = r_idx;
        w_wr.data = w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (zdsa_pkg::t_req'(i_req_type))
                            zdsa_pkg::REQ_ALLOC: begin
                                r_alloc <= 1'b1;
                                r_idx   <= '0;
                                r_state <= S_CHECK;
                            end
                            zdsa_pkg::REQ_MARK: begin
                                if (w_trk_ok && w_sec_ok) begin
                                    r_alloc  <= 1'b0;
                                    r_idx    <= zdsa_pkg::IDX_W'(i_track
                                                - zdsa_pkg::TRK_W'(1));
                                    r_sector <= i_sector;
                                    r_state  <= S_CHECK;
                                end else begin
                                    r_p_status <= zdsa_pkg::ST_RANGE;
                                    r_p_track  <= '0;
                                    r_p_sector <= '0;
                                    r_p_offset <= '0;
                                    r_p_free   <= '0;
                                    r_state    <= S_EMIT;
                                end
                            end
                            zdsa_pkg::REQ_FORMAT: begin
                                r_p_status <= zdsa_pkg::ST_OK;
                                r_p_track  <= '0;
                                r_p_sector <= '0;
                                r_p_offset <= '0;
                                r_p_free   <= '0;
                                r_state    <= S_EMIT;
                            end
                            default: begin
                                r_p_status <= zdsa_pkg::ST_RANGE;
                                r_p_track  <= '0;
                                r_p_sector <= '0;
                                r_p_offset <= '0;
                                r_p_free   <= '0;
                                r_state    <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (r_alloc && !w_found) begin
                        // Track is full: move on, or report a full disk
                        // after the last track.
                        if (r_idx == LAST_IDX) begin
                            r_p_status <= zdsa_pkg::ST_FULL;
                            r_p_track  <= '0;
                            r_p_sector <= '0;
                            r_p_offset <= '0;
                            r_p_free   <= '0;
                            r_state    <= S_EMIT;
                        end else begin
                            r_idx <= r_idx + zdsa_pkg::IDX_W'(1);
                        end
                    end else begin
                        r_p_track  <= w_trk;
                        r_p_sector <= w_sel_sec;
                        r_p_offset <= w_offset;
                        if (r_alloc || w_bit) begin
                            r_p_status <= zdsa_pkg::ST_OK;
                            r_p_free   <= w_new.count;
                        end else begin
                            r_p_status <= zdsa_pkg::ST_USED;
                            r_p_free   <= w_entry.count;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_o_status <= r_p_status;
                        r_o_track  <= r_p_track;
                        r_o_sector <= r_p_sector;
                        r_o_offset <= r_p_offset;
                        r_o_free   <= r_p_free;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_out_track   = r_o_track;
    assign o_out_sector  = r_o_sector;
    assign o_byte_offset = r_o_offset;
    assign o_track_free  = r_o_free;

    // A scan never runs past the last track.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_idx <= LAST_IDX))
        else $error("track index beyond the map");

    // A full-disk result carries no location.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == zdsa_pkg::ST_FULL) |->
        (o_out_track == '0 && o_out_sector == '0 && o_track_free == '0))
        else $error("disk full result carries a location");

    // A granted sector lies on its track.
    a_sector_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == zdsa_pkg::ST_OK && o_out_track != '0) |->
        (o_out_sector < zdsa_pkg::spt(o_out_track)))
        else $error("granted sector beyond track size");

    // The map is written back only while an entry is being examined.
    a_wr_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_state == S_CHECK && !w_rd.en))
        else $error("map write outside the check step");

endmodule

// ----- rtl/zdsa_map_mem.sv -----
// ============================================================================
// zdsa_map_mem - per-track availability map storage
// One entry per track, one read and one write port, registered read data.
// Per-entry valid flags make an unwritten entry read as the fresh map, so
// reset and format take effect at once, with no clearing pass.
// ============================================================================
module zdsa_map_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zdsa_pkg::t_rd_req i_rd,
    input  zdsa_pkg::t_wr_req i_wr,
    input  logic              i_clear,
    output zdsa_pkg::t_entry  o_rd_data
);

    zdsa_pkg::t_entry                   r_mem [zdsa_pkg::NUM_TRACKS];
    logic [zdsa_pkg::NUM_TRACKS-1:0]    r_valid;
    zdsa_pkg::t_entry                   r_rd_raw;
    logic                               r_rd_hit;
    logic [zdsa_pkg::IDX_W-1:0]         r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_raw  <= r_mem[i_rd.addr];
            r_rd_addr <= i_rd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else if (i_rd.en) begin
            r_rd_hit <= r_valid[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_raw : zdsa_pkg::fresh_entry(r_rd_addr);

endmodule

// ----- rtl/zdsa_locate.sv -----
// ============================================================================
// zdsa_locate - lowest free sector finder
// Priority encoder over one track's free bitmap.
// ============================================================================
module zdsa_locate (
    input  logic [zdsa_pkg::MAX_SPT-1:0] i_bitmap,
    output logic                         o_found,
    output logic [zdsa_pkg::SEC_W-1:0]   o_sector
);

    always_comb begin
        o_found  = |i_bitmap;
        o_sector = '0;
        // Walk downward so the lowest set bit wins.
        for (int i = zdsa_pkg::MAX_SPT - 1; i >= 0; i--) begin
            if (i_bitmap[i]) begin
                o_sector = zdsa_pkg::SEC_W'(i);
            end
        end
    end

endmodule
